// File: rtl/core/fpft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpft_pkg
// Shared sizes, types and helpers of the FIFO page frame table.
// ----------------------------------------------------------------------------
package fpft_pkg;

  localparam int FRAMES        = 256;
  localparam int PAGES         = 32;
  localparam int PAGE_BYTES    = 1024;
  localparam int PROCESS_SLOTS = 128;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int COUNT_W = $clog2(FRAMES + 1);
  localparam int PAGE_W  = $clog2(PAGES);
  localparam int PROC_W  = $clog2(PROCESS_SLOTS);
  localparam int ADDR_W  = 16;
  localparam int MAG_W   = ADDR_W + 1;
  localparam int SHIFT_W = $clog2(PAGE_BYTES);
  localparam int ENTRY_W = PROC_W + PAGE_W + 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_EXIT   = 1'b1;

  // One frame table entry as stored in memory
  typedef struct packed {
    logic [PROC_W-1:0] owner;
    logic [PAGE_W-1:0] page;
    logic              dirty;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic hit_done;
    logic fill;
    logic ev_q;
    logic ev_e;
    logic ev_w;
    logic x_init;
    logic x_q;
    logic x_e;
    logic x_d;
    logic x_end;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_exit;
    logic hit;
    logic scan_done;
    logic full;
    logic x_done;
    logic out_busy;
  } status_t;

  // Advance a circular queue pointer
  function automatic logic [FRAME_W-1:0] ptr_inc(input logic [FRAME_W-1:0] p);
    ptr_inc = (p == FRAME_W'(FRAMES - 1)) ? '0 : p + FRAME_W'(1);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/fifo_page_frame_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_page_frame_table_unit
// FIFO page frame table: resolves accesses to frames, evicts oldest, frees on exit.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb up)             | tuser
//  s_axis   | in  | process[6:0], address[22:7]       | operation
//  m_axis   | out | hit, frame, victim_valid, victim_process,
//           |     | victim_page, victim_dirty, freed_count | -
//
// An access walks all 256 frames through the entry memory, one read a cycle;
// a hit ends the walk early. After the walk an eviction reads the queue head,
// then the victim's entry, then writes it; a fill writes an empty frame directly.
// A process exit reads each resident frame's queue slot and entry in turn.
// Reset clears valid bits and the queue pointers at once; no clearing pass.
// A new word is taken only when idle and the result register is empty.
module fifo_page_frame_table_unit
  import fpft_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // process, address, pad
  input  wire logic                  s_axis_tuser_i,  // operation
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o   // hit, frame, victim_valid,
                                                       // victim_process, victim_page,
                                                       // victim_dirty, freed_count
);

  cmd_t    cmd;
  status_t status;

  fpft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpft_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tuser_i),
    .process_i   (s_axis_tdata_i[PROC_W-1:0]),
    .address_i   (s_axis_tdata_i[PROC_W+ADDR_W-1:PROC_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // No new word while a result waits
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o) else $error("ready while result pending");

  // Exit results carry no frame or victim
  a_exit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.x_end |=> (m_axis_tdata_o[22:0] == 23'd0)) else $error("exit result not clean");

  // Access results free nothing
  a_access_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.hit_done || cmd.fill || cmd.ev_w) |=> (m_axis_tdata_o[31:23] == 9'd0))
    else $error("access result with freed count");

  // Resident count never exceeds the frame count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.full |-> !cmd.fill) else $error("fill while full");

endmodule
`default_nettype wire

// File: rtl/core/fpft_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpft_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/fpft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpft_ctrl
// Sequencer of the frame table: scan, fill, evict and process exit.
// ----------------------------------------------------------------------------
module fpft_ctrl
  import fpft_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SCAN = 12'b0000_0000_0010,
    S_HIT  = 12'b0000_0000_0100,
    S_FILL = 12'b0000_0000_1000,
    S_EVQ  = 12'b0000_0001_0000,
    S_EVE  = 12'b0000_0010_0000,
    S_EVW  = 12'b0000_0100_0000,
    S_XIN  = 12'b0000_1000_0000,
    S_XQ   = 12'b0001_0000_0000,
    S_XE   = 12'b0010_0000_0000,
    S_XD   = 12'b0100_0000_0000,
    S_XEND = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !status_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = status_i.op_exit ? S_XIN : S_SCAN;
      end
      S_SCAN: begin
        if (status_i.hit) state_d = S_HIT;
        else if (status_i.scan_done) state_d = status_i.full ? S_EVQ : S_FILL;
      end
      S_HIT:  state_d = S_IDLE;
      S_FILL: state_d = S_IDLE;
      S_EVQ:  state_d = S_EVE;
      S_EVE:  state_d = S_EVW;
      S_EVW:  state_d = S_IDLE;
      S_XIN:  state_d = S_XQ;
      S_XQ: begin
        state_d = status_i.x_done ? S_XEND : S_XE;
      end
      S_XE:   state_d = S_XD;
      S_XD:   state_d = S_XQ;
      S_XEND: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Decode commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.scan     = (state_q == S_SCAN);
    cmd_o.hit_done = (state_q == S_HIT);
    cmd_o.fill     = (state_q == S_FILL);
    cmd_o.ev_q     = (state_q == S_EVQ);
    cmd_o.ev_e     = (state_q == S_EVE);
    cmd_o.ev_w     = (state_q == S_EVW);
    cmd_o.x_init   = (state_q == S_XIN);
    cmd_o.x_q      = (state_q == S_XQ) && !status_i.x_done;
    cmd_o.x_e      = (state_q == S_XE);
    cmd_o.x_d      = (state_q == S_XD);
    cmd_o.x_end    = (state_q == S_XEND);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fpft_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpft_dp
// Datapath: entry memory, arrival queue, valid bits, counters, result word.
// ----------------------------------------------------------------------------
module fpft_dp
  import fpft_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  op_i,
  input  wire logic [PROC_W-1:0]     process_i,
  input  wire logic [ADDR_W-1:0]     address_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  // Latched request
  logic               wr_q;
  logic [PROC_W-1:0]  proc_q;
  logic [PAGE_W-1:0]  page_q;
  logic [MAG_W-1:0]   mag;

  // Table state
  logic [FRAMES-1:0]  used_q;
  logic [COUNT_W-1:0] count_q;
  logic [FRAME_W-1:0] head_q, tail_q;

  // Scan state
  logic [COUNT_W-1:0] scan_idx_q;
  logic               chk_vld_q;
  logic [FRAME_W-1:0] chk_idx_q, tgt_q, free_q;
  logic               free_fnd_q;

  // Exit compaction state
  logic [COUNT_W-1:0] r_q, n_q, freed_q;
  logic [FRAME_W-1:0] rp_q, wp_q, frm_q;

  // Memory ports
  logic               e_we, q_we;
  logic [FRAME_W-1:0] e_waddr, e_raddr, q_waddr, q_raddr, q_rdata, q_wdata;
  entry_t             e_wdata, e_rdata;
  logic [ENTRY_W-1:0] e_rbits;

  // Result register
  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, res_data;
  logic               res_ld;

  logic hit, scan_in_range;

  assign e_rdata = entry_t'(e_rbits);

  // Magnitude of the address, then page number
  assign mag = address_i[ADDR_W-1] ? (MAG_W'(1) << ADDR_W) - MAG_W'(address_i)
                                   : MAG_W'(address_i);

  assign scan_in_range = (scan_idx_q != COUNT_W'(FRAMES));
  assign hit = cmd_i.scan && chk_vld_q && used_q[chk_idx_q] &&
               (e_rdata.owner == proc_q) && (e_rdata.page == page_q);

  assign status_o.op_exit   = op_i;
  assign status_o.hit       = hit;
  assign status_o.scan_done = !scan_in_range && !chk_vld_q;
  assign status_o.full      = (count_q == COUNT_W'(FRAMES));
  assign status_o.x_done    = (r_q == count_q);
  assign status_o.out_busy  = out_valid_q;

  // Entry memory ports; a write hit rewrites the same owner and page, dirty set
  always_comb begin
    e_raddr = scan_idx_q[FRAME_W-1:0];
    if (cmd_i.ev_e || cmd_i.x_e) e_raddr = q_rdata;
    e_we    = cmd_i.fill || cmd_i.ev_w || (cmd_i.hit_done && wr_q);
    e_waddr = cmd_i.fill ? free_q : tgt_q;
    e_wdata.owner = proc_q;
    e_wdata.page  = page_q;
    e_wdata.dirty = wr_q;
  end

  // Queue memory ports
  always_comb begin
    q_raddr = cmd_i.ev_q ? head_q : rp_q;
    q_we    = cmd_i.fill || cmd_i.ev_w || (cmd_i.x_d && (e_rdata.owner != proc_q));
    q_waddr = cmd_i.x_d ? wp_q : tail_q;
    q_wdata = cmd_i.fill ? free_q : (cmd_i.x_d ? frm_q : tgt_q);
  end

  fpft_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAMES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rbits)
  );

  fpft_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Build the result word
  always_comb begin
    res_ld   = cmd_i.hit_done || cmd_i.fill || cmd_i.ev_w || cmd_i.x_end;
    res_data = '0;
    if (cmd_i.hit_done) begin
      res_data[0]   = 1'b1;
      res_data[8:1] = tgt_q;
    end else if (cmd_i.fill) begin
      res_data[8:1] = free_q;
    end else if (cmd_i.ev_w) begin
      res_data[8:1]   = tgt_q;
      res_data[9]     = 1'b1;
      res_data[16:10] = e_rdata.owner;
      res_data[21:17] = e_rdata.page;
      res_data[22]    = e_rdata.dirty;
    end else begin
      res_data[31:23] = freed_q;
    end
  end

  // Request latch and payload working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wr_q   <= address_i[ADDR_W-1];
      proc_q <= process_i;
      page_q <= PAGE_W'(mag >> SHIFT_W);
    end
    if (hit) tgt_q <= chk_idx_q;
    if (cmd_i.scan) chk_idx_q <= scan_idx_q[FRAME_W-1:0];
    if (cmd_i.ev_e) tgt_q <= q_rdata;
    if (cmd_i.x_e) frm_q <= q_rdata;
    if (cmd_i.scan && scan_in_range && !free_fnd_q && !used_q[scan_idx_q[FRAME_W-1:0]]) begin
      free_q <= scan_idx_q[FRAME_W-1:0];
    end
    if (res_ld) out_data_q <= res_data;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      scan_idx_q  <= '0;
      chk_vld_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      r_q         <= '0;
      n_q         <= '0;
      freed_q     <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Start a scan
      if (cmd_i.accept) begin
        scan_idx_q <= '0;
        chk_vld_q  <= 1'b0;
        free_fnd_q <= 1'b0;
      end
      // Walk the frames one per cycle
      if (cmd_i.scan) begin
        chk_vld_q <= scan_in_range;
        if (scan_in_range) begin
          scan_idx_q <= scan_idx_q + COUNT_W'(1);
          if (!used_q[scan_idx_q[FRAME_W-1:0]]) free_fnd_q <= 1'b1;
        end
      end
      // Load into the lowest empty frame
      if (cmd_i.fill) begin
        used_q[free_q] <= 1'b1;
        tail_q         <= ptr_inc(tail_q);
        count_q        <= count_q + COUNT_W'(1);
      end
      // Replace the oldest frame
      if (cmd_i.ev_w) begin
        head_q <= ptr_inc(head_q);
        tail_q <= ptr_inc(tail_q);
      end
      // Process exit: compact the queue
      if (cmd_i.x_init) begin
        r_q     <= '0;
        n_q     <= '0;
        freed_q <= '0;
        rp_q    <= head_q;
        wp_q    <= head_q;
      end
      if (cmd_i.x_d) begin
        r_q  <= r_q + COUNT_W'(1);
        rp_q <= ptr_inc(rp_q);
        if (e_rdata.owner == proc_q) begin
          used_q[frm_q] <= 1'b0;
          freed_q       <= freed_q + COUNT_W'(1);
        end else begin
          wp_q <= ptr_inc(wp_q);
          n_q  <= n_q + COUNT_W'(1);
        end
      end
      if (cmd_i.x_end) begin
        tail_q  <= wp_q;
        count_q <= n_q;
      end
      // Hold the result until taken
      if (res_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// File: tb/sv/fpft_checker.sv
// ----------------------------------------------------------------------------
// fpft_checker
// Watches both streams of the frame table, predicts each result word from
// its own copy of the table, and counts mismatches.
// ----------------------------------------------------------------------------
module fpft_checker
  import fpft_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  input  wire logic                  s_ready_i,
  input  wire logic [IN_DATA_W-1:0]  s_data_i,
  input  wire logic                  s_user_i,
  input  wire logic                  m_valid_i,
  input  wire logic                  m_ready_i,
  input  wire logic [OUT_DATA_W-1:0] m_data_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         result_count_o,
  output int                         evict_count_o,
  output int                         exit_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0]         freed_count;
    logic               victim_dirty;
    logic [PAGE_W-1:0]  victim_page;
    logic [PROC_W-1:0]  victim_process;
    logic               victim_valid;
    logic [FRAME_W-1:0] frame;
    logic               hit;
  } lookup_t;

  // shadow frame table
  logic              used_q  [FRAMES];
  logic [PROC_W-1:0] owner_q [FRAMES];
  logic [PAGE_W-1:0] page_q  [FRAMES];
  logic              dirty_q [FRAMES];
  int                rank_q  [FRAMES];
  int                resident;
  lookup_t           lookup_queue[$];

  // free all frames of one process and close up arrival order
  function automatic int release_frames(logic [PROC_W-1:0] proc);
    int order[FRAMES];
    int freed, kept;
    freed = 0;
    kept  = 0;
    foreach (order[i]) order[i] = -1;
    for (int f = 0; f < FRAMES; f++) if (used_q[f]) order[rank_q[f]] = f;
    for (int r = 0; r < FRAMES; r++) begin
      if (order[r] >= 0) begin
        if (owner_q[order[r]] == proc) begin
          used_q[order[r]]  = 1'b0;
          owner_q[order[r]] = '0;
          page_q[order[r]]  = '0;
          dirty_q[order[r]] = 1'b0;
          freed++;
        end else begin
          rank_q[order[r]] = kept;
          kept++;
        end
      end
    end
    resident = kept;
    return freed;
  endfunction

  // resolve one word against the shadow table
  function automatic lookup_t resolve_word(logic op, logic [IN_DATA_W-1:0] d);
    lookup_t           res;
    logic [PROC_W-1:0] proc;
    logic [15:0]       addr;
    logic              wr;
    logic [16:0]       mag;
    logic [PAGE_W-1:0] pg;
    int                tgt;
    res  = '0;
    proc = d[6:0];
    addr = d[22:7];
    wr   = addr[15];
    mag  = wr ? (17'h10000 - {1'b0, addr}) : {1'b0, addr};
    pg   = PAGE_W'(mag / PAGE_BYTES);
    if (op == OP_EXIT) begin
      res.freed_count = 9'(release_frames(proc));
      return res;
    end
    for (int f = 0; f < FRAMES; f++) begin
      if (used_q[f] && owner_q[f] == proc && page_q[f] == pg) begin
        if (wr) dirty_q[f] = 1'b1;
        res.hit   = 1'b1;
        res.frame = FRAME_W'(f);
        return res;
      end
    end
    tgt = 0;
    if (resident < FRAMES) begin
      for (int f = FRAMES - 1; f >= 0; f--) if (!used_q[f]) tgt = f;
      rank_q[tgt] = resident;
      resident++;
    end else begin
      for (int f = FRAMES - 1; f >= 0; f--) if (rank_q[f] == 0) tgt = f;
      res.victim_valid   = 1'b1;
      res.victim_process = owner_q[tgt];
      res.victim_page    = page_q[tgt];
      res.victim_dirty   = dirty_q[tgt];
      for (int f = 0; f < FRAMES; f++) if (f != tgt) rank_q[f]--;
      rank_q[tgt] = FRAMES - 1;
    end
    used_q[tgt]  = 1'b1;
    owner_q[tgt] = proc;
    page_q[tgt]  = pg;
    dirty_q[tgt] = wr;
    res.frame    = FRAME_W'(tgt);
    return res;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want, got;
    if (!rst_ni) begin
      foreach (used_q[i]) begin
        used_q[i] = 1'b0; owner_q[i] = '0; page_q[i] = '0; dirty_q[i] = 1'b0;
        rank_q[i] = 0;
      end
      resident = 0;
      lookup_queue.delete();
      pending_o = 0;
      fail_count_o = 0; result_count_o = 0; evict_count_o = 0; exit_count_o = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        want = resolve_word(s_user_i, s_data_i);
        if (want.victim_valid) evict_count_o++;
        if (s_user_i == OP_EXIT) exit_count_o++;
        lookup_queue.push_back(want);
      end
      if (m_valid_i && m_ready_i) begin
        got = lookup_t'(m_data_i[$bits(lookup_t)-1:0]);
        result_count_o++;
        if (lookup_queue.size() == 0) begin
          $error("result word with nothing expected: %h", m_data_i);
          fail_count_o++;
        end else begin
          want = lookup_queue.pop_front();
          if (got.hit != want.hit) begin
            $error("hit: expected %0d got %0d", want.hit, got.hit); fail_count_o++;
          end
          if (got.frame != want.frame) begin
            $error("frame: expected %0d got %0d", want.frame, got.frame); fail_count_o++;
          end
          if (got.victim_valid != want.victim_valid) begin
            $error("victim_valid: expected %0d got %0d", want.victim_valid,
                   got.victim_valid);
            fail_count_o++;
          end
          if (got.victim_process != want.victim_process) begin
            $error("victim_process: expected %0d got %0d", want.victim_process,
                   got.victim_process);
            fail_count_o++;
          end
          if (got.victim_page != want.victim_page) begin
            $error("victim_page: expected %0d got %0d", want.victim_page,
                   got.victim_page);
            fail_count_o++;
          end
          if (got.victim_dirty != want.victim_dirty) begin
            $error("victim_dirty: expected %0d got %0d", want.victim_dirty,
                   got.victim_dirty);
            fail_count_o++;
          end
          if (got.freed_count != want.freed_count) begin
            $error("freed_count: expected %0d got %0d", want.freed_count,
                   got.freed_count);
            fail_count_o++;
          end
        end
      end
      pending_o = lookup_queue.size();
    end
  end

endmodule

// File: tb/sv/tb_fifo_page_frame_table_unit.sv
// ----------------------------------------------------------------------------
// tb_fifo_page_frame_table_unit
// Drives accesses and process exits into the frame table with random gaps
// and back-pressure; a checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module tb_fifo_page_frame_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fpft_pkg::*;

  localparam int RANDOM_WORDS = 1080;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = OP_ACCESS;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  int     fail_count, pending, result_count, evict_count, exit_count;
  int     send_idle_pct = 15;
  int     recv_idle_pct = 72;
  bit     hold_off = 1'b0;
  longint cycle_count = 0;
  int     word_count = 0;

  fifo_page_frame_table_unit DUT (.*);

  fpft_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o),
    .s_data_i(s_axis_tdata_i), .s_user_i(s_axis_tuser_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i),
    .m_data_i(m_axis_tdata_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count),
    .evict_count_o(evict_count), .exit_count_o(exit_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_fifo_page_frame_table_unit: errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // offer one word and wait for it to be taken; the next call or a drain drops valid
  task automatic send_word(logic op, logic [PROC_W-1:0] proc, logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {1'b0, addr, proc};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    word_count++;
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // random page in a small working set so hits and evictions both occur
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    a = 16'($urandom_range(PAGES * PAGE_BYTES - 1));
    if ($urandom_range(99) < 10) a = 16'($urandom);
    else if ($urandom_range(1)) a = -a;
    return a;
  endfunction

  initial begin
    logic [PROC_W-1:0] proc;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, reads and writes, hits, empty exit
    send_word(OP_ACCESS, 7'd0, 16'd0);
    send_word(OP_ACCESS, 7'd0, 16'd0);
    send_word(OP_ACCESS, 7'd127, 16'h7FFF);
    send_word(OP_ACCESS, 7'd127, 16'h8001);
    send_word(OP_ACCESS, 7'd5, 16'h8000);
    send_word(OP_ACCESS, 7'd5, 16'd1023);
    send_word(OP_ACCESS, 7'd5, -16'sd1024);
    send_word(OP_ACCESS, 7'd85, 16'h5555);
    send_word(OP_ACCESS, 7'd42, 16'hAAAA);
    send_word(OP_EXIT, 7'd99, 16'hFFFF);
    send_word(OP_EXIT, 7'd5, 16'd0);
    send_word(OP_ACCESS, 7'd3, 16'd2048);
    send_word(OP_EXIT, 7'd127, 16'h1234);
    send_word(OP_EXIT, 7'd0, 16'd0);

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) send_word(OP_ACCESS, 7'($urandom), pick_addr());
    join
    drain_results();

    // random: three idling phases; fill past 256 frames to force evictions
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        send_idle_pct = 72; recv_idle_pct = 15;
      end else if (i == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (i == RANDOM_WORDS / 2) drain_results();
      proc = 7'($urandom_range(15));
      if ($urandom_range(99) < 5) proc = 7'($urandom);
      if ($urandom_range(99) < 3) send_word(OP_EXIT, proc, 16'($urandom));
      else send_word(OP_ACCESS, proc, pick_addr());
    end

    drain_results();
    repeat (1000) @(posedge clk_i);
    $display("covered %0d words, %0d results, %0d evictions, %0d exits",
             word_count, result_count, evict_count, exit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_fifo_page_frame_table_unit: clean");
    end else begin
      $display("tb_fifo_page_frame_table_unit: errors");
    end
    $finish;
  end

endmodule
